/* sv/frls_pkg.sv */
// shared types and codes for the ready-list scheduler
`timescale 1ns / 1ps

package frls_pkg;

  localparam int IDLE_SLOT = 0;
  localparam int TID_W     = 4;

  typedef enum logic [1:0] {
    KIND_RESUME  = 2'd0,
    KIND_SUSPEND = 2'd1,
    KIND_ADVANCE = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_SAME   = 2'd1,
    ST_REJECT = 2'd2
  } status_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic [TID_W-1:0] thread_id;
  } in_item_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [TID_W-1:0] running_thread;
  } out_item_t;

endpackage

/* sv/fcfs_ready_list_scheduler_top.sv */
// ready-list scheduler top: input register, link update and result register
//
//   channel | direction | handshake          | payload
//   in      | input     | in_valid/in_stall  | in_data: kind, thread_id
//   out     | output    | out_valid/out_stall| out_data: status, running_thread
//
// one transaction per cycle unless stalled, via the input and result registers
// the link tables in flops are read and written once per item in one pass
// synchronous active-low reset clears both valid flags, the current thread
// and all links to the idle slot
// a stalled result holds the input register, which then stalls the input side
`timescale 1ns / 1ps

module fcfs_ready_list_scheduler_top #(
  parameter int THREAD_SLOTS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  frls_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output frls_pkg::out_item_t out_data
);
  import frls_pkg::*;

  localparam int LW = $clog2(THREAD_SLOTS);
  localparam logic [LW-1:0] IDLE = LW'(IDLE_SLOT);

  logic                  s1_vld_r, s1_vld_nxt;
  in_item_t              s1_item_r;
  logic                  out_vld_r, out_vld_nxt;
  out_item_t             out_item_r, out_item_nxt;
  logic [LW-1:0]         cur_r;
  logic                  s1_go;
  logic                  in_take;
  logic [4*(2*LW+1)-1:0] upd;
  logic [LW-1:0]         next0, prev0, next_t, prev_t, next_cur, rd_t;
  status_t               status;
  logic                  cur_we;
  logic [LW-1:0]         cur_nxt;
  logic [LW-1:0]         run_sel;
  logic [LW+TID_W-1:0]   run_ext;

  assign s1_go       = s1_vld_r && (!out_vld_r || !out_stall);
  assign in_stall    = s1_vld_r && !s1_go;
  assign in_take     = in_valid && !in_stall;
  assign s1_vld_nxt  = in_take || (s1_vld_r && !s1_go);
  assign out_vld_nxt = s1_go || (out_vld_r && out_stall);

  frls_update #(.THREAD_SLOTS(THREAD_SLOTS), .LW(LW)) u_update (
    .go       (s1_go),
    .item     (s1_item_r),
    .next0    (next0),
    .prev0    (prev0),
    .next_t   (next_t),
    .prev_t   (prev_t),
    .next_cur (next_cur),
    .rd_t     (rd_t),
    .upd      (upd),
    .status   (status),
    .cur_we   (cur_we),
    .cur_nxt  (cur_nxt)
  );

  frls_links #(.THREAD_SLOTS(THREAD_SLOTS), .LW(LW)) u_links (
    .clk      (clk),
    .rst_n    (rst_n),
    .upd      (upd),
    .rd_t     (rd_t),
    .rd_cur   (cur_r),
    .next0    (next0),
    .prev0    (prev0),
    .next_t   (next_t),
    .prev_t   (prev_t),
    .next_cur (next_cur)
  );

  assign run_sel = cur_we ? cur_nxt : cur_r;
  assign run_ext = {{TID_W{1'b0}}, run_sel};
  assign out_item_nxt = '{status: status, running_thread: run_ext[TID_W-1:0]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      cur_r     <= IDLE;
    end else begin
      s1_vld_r  <= s1_vld_nxt;
      out_vld_r <= out_vld_nxt;
      if (cur_we) begin
        cur_r <= cur_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_item_r <= in_data;
    end
    if (s1_go) begin
      out_item_r <= out_item_nxt;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_item_r;

  a_go_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    s1_go |=> out_vld_r)
    else $error("processed transaction did not reach result register");

  a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_vld_r && out_vld_r && out_stall))
    else $error("input stalled without a blocked transaction");

  a_cur_only_on_advance: assert property (@(posedge clk) disable iff (!rst_n)
    cur_we |-> (s1_go && s1_item_r.kind == KIND_ADVANCE))
    else $error("running thread changed outside advance");

  a_advance_follows_link: assert property (@(posedge clk) disable iff (!rst_n)
    cur_we |=> cur_r == $past(next_cur))
    else $error("advance did not follow the next link");

  a_reject_keeps_cur: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_go && status == ST_REJECT) |=> cur_r == $past(cur_r))
    else $error("rejected transaction moved the running thread");

endmodule

/* sv/frls_links.sv */
// next and prev link tables in flops with two ordered write ports each
`timescale 1ns / 1ps

module frls_links #(
  parameter int THREAD_SLOTS = 16,
  parameter int LW = $clog2(THREAD_SLOTS)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic [4*(2*LW+1)-1:0] upd,
  input  logic [LW-1:0] rd_t,
  input  logic [LW-1:0] rd_cur,
  output logic [LW-1:0] next0,
  output logic [LW-1:0] prev0,
  output logic [LW-1:0] next_t,
  output logic [LW-1:0] prev_t,
  output logic [LW-1:0] next_cur
);
  import frls_pkg::*;

  typedef struct packed {
    logic          we;
    logic [LW-1:0] wa;
    logic [LW-1:0] wd;
  } link_wr_t;

  typedef struct packed {
    link_wr_t nxt_a;
    link_wr_t nxt_b;
    link_wr_t prv_a;
    link_wr_t prv_b;
  } link_upd_t;

  localparam logic [LW-1:0] IDLE = LW'(IDLE_SLOT);

  link_upd_t     wr;
  logic [LW-1:0] next_r   [THREAD_SLOTS];
  logic [LW-1:0] prev_r   [THREAD_SLOTS];
  logic [LW-1:0] next_nxt [THREAD_SLOTS];
  logic [LW-1:0] prev_nxt [THREAD_SLOTS];

  assign wr = upd;

  always_comb begin
    for (int i = 0; i < THREAD_SLOTS; i++) begin
      next_nxt[i] = next_r[i];
      if (wr.nxt_a.we && wr.nxt_a.wa == LW'(i)) next_nxt[i] = wr.nxt_a.wd;
      if (wr.nxt_b.we && wr.nxt_b.wa == LW'(i)) next_nxt[i] = wr.nxt_b.wd;
      prev_nxt[i] = prev_r[i];
      if (wr.prv_a.we && wr.prv_a.wa == LW'(i)) prev_nxt[i] = wr.prv_a.wd;
      if (wr.prv_b.we && wr.prv_b.wa == LW'(i)) prev_nxt[i] = wr.prv_b.wd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < THREAD_SLOTS; i++) begin
        next_r[i] <= IDLE;
        prev_r[i] <= IDLE;
      end
    end else begin
      for (int i = 0; i < THREAD_SLOTS; i++) begin
        next_r[i] <= next_nxt[i];
        prev_r[i] <= prev_nxt[i];
      end
    end
  end

  assign next0    = next_r[IDLE];
  assign prev0    = prev_r[IDLE];
  assign next_t   = (32'(rd_t) < THREAD_SLOTS) ? next_r[rd_t] : IDLE;
  assign prev_t   = (32'(rd_t) < THREAD_SLOTS) ? prev_r[rd_t] : IDLE;
  assign next_cur = (32'(rd_cur) < THREAD_SLOTS) ? next_r[rd_cur] : IDLE;

endmodule

/* sv/frls_update.sv */
// resume, suspend and advance decode into link writes and status
`timescale 1ns / 1ps

module frls_update #(
  parameter int THREAD_SLOTS = 16,
  parameter int LW = $clog2(THREAD_SLOTS)
) (
  input  logic                 go,
  input  frls_pkg::in_item_t   item,
  input  logic [LW-1:0]        next0,
  input  logic [LW-1:0]        prev0,
  input  logic [LW-1:0]        next_t,
  input  logic [LW-1:0]        prev_t,
  input  logic [LW-1:0]        next_cur,
  output logic [LW-1:0]        rd_t,
  output logic [4*(2*LW+1)-1:0] upd,
  output frls_pkg::status_t    status,
  output logic                 cur_we,
  output logic [LW-1:0]        cur_nxt
);
  import frls_pkg::*;

  typedef struct packed {
    logic          we;
    logic [LW-1:0] wa;
    logic [LW-1:0] wd;
  } link_wr_t;

  typedef struct packed {
    link_wr_t nxt_a;
    link_wr_t nxt_b;
    link_wr_t prv_a;
    link_wr_t prv_b;
  } link_upd_t;

  localparam logic [LW-1:0] IDLE = LW'(IDLE_SLOT);

  link_upd_t         wr;
  logic [LW+TID_W-1:0] tid_ext;
  logic [LW-1:0]     t;
  logic              tid_ok;
  logic              ready_t;
  logic              empty;
  kind_t             kind;

  assign tid_ext = {{LW{1'b0}}, item.thread_id};
  assign t       = tid_ext[LW-1:0];
  assign rd_t    = t;
  assign tid_ok  = (32'(item.thread_id) != IDLE_SLOT) &&
                   (32'(item.thread_id) < THREAD_SLOTS);
  assign ready_t = next_t != IDLE;
  assign empty   = next0 == IDLE;
  assign kind    = kind_t'(item.kind);
  assign cur_nxt = next_cur;
  assign upd     = wr;

  always_comb begin
    wr     = '0;
    status = ST_OK;
    cur_we = 1'b0;
    unique case (kind)
      KIND_RESUME: begin
        if (!tid_ok) begin
          status = ST_REJECT;
        end else if (ready_t) begin
          status = ST_SAME;
        end else begin
          // append at tail
          wr.nxt_a = '{we: go, wa: empty ? IDLE : prev0, wd: t};
          wr.nxt_b = '{we: go, wa: t,
                       wd: (empty || prev0 == IDLE) ? t : next0};
          wr.prv_a = '{we: go, wa: t, wd: prev0};
          wr.prv_b = '{we: go, wa: IDLE, wd: t};
        end
      end
      KIND_SUSPEND: begin
        if (!tid_ok) begin
          status = ST_REJECT;
        end else if (!ready_t) begin
          status = ST_SAME;
        end else begin
          priority if (next0 == t && prev0 == t) begin
            wr.nxt_a = '{we: go, wa: IDLE, wd: IDLE};
            wr.prv_a = '{we: go, wa: IDLE, wd: IDLE};
          end else if (next0 == t) begin
            wr.nxt_a = '{we: go, wa: IDLE, wd: next_t};
            wr.prv_a = '{we: go, wa: next_t, wd: prev0};
          end else if (prev0 == t) begin
            wr.nxt_a = '{we: go, wa: prev_t, wd: next0};
            wr.prv_a = '{we: go, wa: IDLE, wd: prev_t};
          end else begin
            wr.nxt_a = '{we: go, wa: prev_t, wd: next_t};
            wr.prv_a = '{we: go, wa: next_t, wd: prev_t};
          end
          // unlinked slot points back at idle
          wr.nxt_b = '{we: go, wa: t, wd: IDLE};
          wr.prv_b = '{we: go, wa: t, wd: IDLE};
        end
      end
      KIND_ADVANCE: begin
        cur_we = go;
      end
      default: begin
      end
    endcase
  end

endmodule

/* verif/tb.sv */
// testbench for the ready-list scheduler: link-table prediction, random traffic, stalls
`timescale 1ns / 1ps

module tb;
  import frls_pkg::*;

  localparam int                 SLOTS       = 16;
  localparam logic [TID_W-1:0]   IDLE_TID    = TID_W'(IDLE_SLOT);
  localparam logic [1:0]         KIND_UNUSED = 2'd3;
  localparam int                 RAND_ITEMS  = 500;
  localparam int                 LONG_HOLD   = 80;
  localparam int                 QUIET_LIMIT = 3000;

  class ready_list_board;
    logic [TID_W-1:0] next_of[SLOTS];
    logic [TID_W-1:0] prev_of[SLOTS];
    logic [TID_W-1:0] running;
    out_item_t        due_results[$];
    int               errors;

    function new();
      for (int i = 0; i < SLOTS; i++) begin
        next_of[i] = IDLE_TID;
        prev_of[i] = IDLE_TID;
      end
      running = IDLE_TID;
      errors  = 0;
    endfunction

    function status_t resume_thread(logic [TID_W-1:0] t);
      logic [TID_W-1:0] tail;
      if (next_of[t] != IDLE_TID) return ST_SAME;
      tail = prev_of[IDLE_TID];
      if (next_of[IDLE_TID] == IDLE_TID) next_of[IDLE_TID] = t;
      else next_of[tail] = t;
      next_of[t] = next_of[IDLE_TID];
      prev_of[t] = tail;
      prev_of[IDLE_TID] = t;
      return ST_OK;
    endfunction

    function status_t suspend_thread(logic [TID_W-1:0] t);
      logic [TID_W-1:0] head;
      logic [TID_W-1:0] tail;
      logic [TID_W-1:0] a;
      logic [TID_W-1:0] b;
      if (next_of[t] == IDLE_TID) return ST_SAME;
      head = next_of[IDLE_TID];
      tail = prev_of[IDLE_TID];
      if (head == t && tail == t) begin
        next_of[IDLE_TID] = IDLE_TID;
        prev_of[IDLE_TID] = IDLE_TID;
      end else if (head == t) begin
        // prev link of the head is stale, never read here
        a = next_of[t];
        next_of[IDLE_TID] = a;
        prev_of[a] = tail;
      end else if (tail == t) begin
        a = prev_of[t];
        prev_of[IDLE_TID] = a;
        next_of[a] = head;
      end else begin
        a = prev_of[t];
        b = next_of[t];
        next_of[a] = b;
        prev_of[b] = a;
      end
      next_of[t] = IDLE_TID;
      prev_of[t] = IDLE_TID;
      return ST_OK;
    endfunction

    function void note_request(in_item_t item);
      out_item_t want;
      status_t   st;
      st = ST_OK;
      case (item.kind)
        KIND_RESUME, KIND_SUSPEND: begin
          if (item.thread_id == IDLE_TID) st = ST_REJECT;
          else if (item.kind == KIND_RESUME) st = resume_thread(item.thread_id);
          else st = suspend_thread(item.thread_id);
        end
        KIND_ADVANCE: running = next_of[running];
        default: ;
      endcase
      want.status         = st;
      want.running_thread = running;
      due_results.push_back(want);
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (due_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual status %0d running %0d",
                 $time, got.status, got.running_thread);
        return;
      end
      want = due_results.pop_front();
      if (got.status !== want.status) begin
        errors++;
        $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
      end
      if (got.running_thread !== want.running_thread) begin
        errors++;
        $display("%0t: running_thread expected %0d actual %0d",
                 $time, want.running_thread, got.running_thread);
      end
    endfunction

    function int pending();
      return due_results.size();
    endfunction
  endclass

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;

  bit hold_long = 1'b0;
  bit steady    = 1'b0;
  int quiet     = 0;

  ready_list_board sb = new();

  fcfs_ready_list_scheduler_top #(.THREAD_SLOTS(SLOTS)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 60) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic in_item_t make_item(logic [1:0] kind, logic [TID_W-1:0] tid);
    in_item_t r;
    r.kind      = kind;
    r.thread_id = tid;
    return r;
  endfunction

  function automatic in_item_t rand_item();
    in_item_t r;
    int       p;
    p = $urandom_range(0, 99);
    if (p < 38) r.kind = KIND_RESUME;
    else if (p < 70) r.kind = KIND_SUSPEND;
    else if (p < 95) r.kind = KIND_ADVANCE;
    else r.kind = KIND_UNUSED;
    if ($urandom_range(0, 19) == 0) r.thread_id = IDLE_TID;
    else r.thread_id = TID_W'($urandom_range(1, SLOTS - 1));
    return r;
  endfunction

  task automatic send_item(input in_item_t item, input bit gaps);
    int g;
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall);
    if (gaps) begin
      g = pick_gap();
      if (g > 0) begin
        in_valid <= 1'b0;
        repeat (g) @(posedge clk);
      end
    end
  endtask

  task automatic wait_all_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  // transaction monitor
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) sb.note_request(in_data);
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, quiet);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // receiver side
  initial begin
    int hold;
    out_stall = 1'b0;
    @(posedge clk);
    forever begin
      if (hold_long) begin
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        hold_long = 1'b0;
      end else if (steady) begin
        out_stall <= 1'b0;
        @(posedge clk);
      end else begin
        hold = pick_gap();
        if (hold == 0) begin
          out_stall <= 1'b0;
          @(posedge clk);
        end else begin
          out_stall <= 1'b1;
          repeat (hold) @(posedge clk);
        end
      end
    end
  end

  // sender side
  initial begin
    bit gaps;
    in_valid = 1'b0;
    in_data  = '0;
    rst_n    = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty list, idle slot, not-ready suspend
    send_item(make_item(KIND_ADVANCE, 4'd9), 1'b1);
    send_item(make_item(KIND_RESUME, IDLE_TID), 1'b1);
    send_item(make_item(KIND_SUSPEND, IDLE_TID), 1'b1);
    send_item(make_item(KIND_SUSPEND, 4'd5), 1'b1);
    // build 1, 15, 7 and resume a ready thread again
    send_item(make_item(KIND_RESUME, 4'd1), 1'b1);
    send_item(make_item(KIND_RESUME, 4'd15), 1'b1);
    send_item(make_item(KIND_RESUME, 4'd7), 1'b1);
    send_item(make_item(KIND_RESUME, 4'd1), 1'b1);
    send_item(make_item(KIND_ADVANCE, 4'd0), 1'b1);
    send_item(make_item(KIND_ADVANCE, 4'd15), 1'b1);
    // middle removal of the running thread, then advance falls to idle
    send_item(make_item(KIND_SUSPEND, 4'd15), 1'b1);
    send_item(make_item(KIND_ADVANCE, 4'd0), 1'b1);
    send_item(make_item(KIND_ADVANCE, 4'd0), 1'b1);
    send_item(make_item(KIND_SUSPEND, 4'd1), 1'b1);
    send_item(make_item(KIND_SUSPEND, 4'd7), 1'b1);
    // tail, head and single removal
    send_item(make_item(KIND_RESUME, 4'd3), 1'b1);
    send_item(make_item(KIND_RESUME, 4'd9), 1'b1);
    send_item(make_item(KIND_RESUME, 4'd12), 1'b1);
    send_item(make_item(KIND_SUSPEND, 4'd12), 1'b1);
    send_item(make_item(KIND_SUSPEND, 4'd3), 1'b1);
    send_item(make_item(KIND_SUSPEND, 4'd9), 1'b1);
    // unused kind
    send_item(make_item(KIND_UNUSED, 4'd10), 1'b1);
    send_item(make_item(KIND_UNUSED, 4'd15), 1'b1);
    send_item(make_item(KIND_ADVANCE, 4'd15), 1'b1);

    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n == 150) hold_long = 1'b1;
      if (n == 190) wait_all_results();
      if (n == 260) steady = 1'b1;
      if (n == 330) steady = 1'b0;
      gaps = !(n >= 150 && n < 190) && !steady;
      send_item(rand_item(), gaps);
    end

    wait_all_results();
    repeat (10) @(posedge clk);
    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
